// ----- rtl/hsv_pkg.sv -----
// Shared constants, codes and stage payload types for the HSV to RGB converter.
`default_nettype none

package hsv_pkg;

   localparam int HUE_W       = 9;
   localparam int CHAN_W      = 8;
   localparam int FRAC_W      = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam int SECTOR_DEG  = 60;
   localparam int FULL_SCALE  = 255;
   localparam int FRAC_SCALE  = SECTOR_DEG * FULL_SCALE;

   // Hue div 60 as a multiply by 1093 / 2^16, exact for every 9-bit hue.
   localparam int HUE_RECIP       = 1093;
   localparam int HUE_RECIP_SHIFT = 16;
   localparam int HUE_PROD_W      = 20;
   localparam int HUE_QUOT_W      = 4;

   // Division by 15300 as a multiply by ceil(2^36 / 15300), exact below 2^22.
   localparam int FRAC_RECIP       = 4491470;
   localparam int FRAC_RECIP_SHIFT = 36;
   localparam int NUM_W            = 14;
   localparam int MUL_W            = 22;
   localparam int RECIP_PROD_W     = 45;
   localparam int P_MUL_W          = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SATURATION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS = 2'd1;

   typedef enum logic [2:0] {
      SECT_RED_YELLOW   = 3'd0,
      SECT_YELLOW_GREEN = 3'd1,
      SECT_GREEN_CYAN   = 3'd2,
      SECT_CYAN_BLUE    = 3'd3,
      SECT_BLUE_MAGENTA = 3'd4,
      SECT_MAGENTA_RED  = 3'd5
   } hsv_sector_type;

   typedef struct packed {
      hsv_sector_type    sector;
      logic [FRAC_W-1:0] frac;
   } hsv_angle_type;

   typedef struct packed {
      hsv_sector_type    sector;
      logic [CHAN_W-1:0] level_p;
      logic [CHAN_W-1:0] level_q;
      logic [CHAN_W-1:0] level_t;
   } hsv_level_type;

endpackage

`default_nettype wire

// ----- rtl/hsv_sector.sv -----
// First pipeline stage: splits the hue into a sector and a position within it.
`default_nettype none

module hsv_sector
   import hsv_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [HUE_W-1:0] in_hue,
   output logic                  in_ready,
   output logic                  out_valid,
   output hsv_angle_type         out_angle,
   input  wire logic             out_ready
);

   logic [HUE_PROD_W-1:0] quot_prod;
   logic [HUE_QUOT_W-1:0] quot;
   logic [HUE_QUOT_W-1:0] sect_wrap;
   logic [HUE_W:0]        base;
   logic [HUE_W:0]        remain;
   logic                  vld_ff;
   logic                  vld_in;
   hsv_angle_type         angle_ff;
   hsv_angle_type         angle_in;

   always_comb begin
      quot_prod = HUE_PROD_W'(in_hue) * HUE_PROD_W'(HUE_RECIP);
      quot      = quot_prod[HUE_RECIP_SHIFT +: HUE_QUOT_W];
      base      = (HUE_W+1)'(quot) * (HUE_W+1)'(SECTOR_DEG);
      remain    = (HUE_W+1)'(in_hue) - base;
      if (quot >= HUE_QUOT_W'(6)) begin
         sect_wrap = quot - HUE_QUOT_W'(6);
      end else begin
         sect_wrap = quot;
      end
      angle_in.sector = hsv_sector_type'(sect_wrap[2:0]);
      angle_in.frac   = remain[FRAC_W-1:0];
   end

   assign in_ready  = !vld_ff || out_ready;
   assign vld_in    = in_ready ? in_valid : vld_ff;
   assign out_valid = vld_ff;
   assign out_angle = angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (in_ready && in_valid) begin
         angle_ff <= angle_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hsv_scale.sv -----
// Three pipeline stages that form the p, q and t levels from saturation and brightness.
`default_nettype none

module hsv_scale
   import hsv_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CHAN_W-1:0] saturation,
   input  wire logic [CHAN_W-1:0] brightness,
   input  wire logic              in_valid,
   input  wire hsv_angle_type     in_angle,
   output logic                   in_ready,
   output logic                   out_valid,
   output hsv_level_type          out_level,
   input  wire logic              out_ready
);

   // Stage A: numerators.
   logic                rdy_a;
   logic                vld_a_ff;
   hsv_sector_type      sect_a_ff;
   logic [NUM_W-1:0]    num_q_a_ff;
   logic [NUM_W-1:0]    num_t_a_ff;
   logic [CHAN_W-1:0]   num_p_a_ff;
   logic [NUM_W-1:0]    num_q_a_in;
   logic [NUM_W-1:0]    num_t_a_in;
   logic [CHAN_W-1:0]   num_p_a_in;
   logic [FRAC_W:0]     rest_frac;

   // Stage B: products with the brightness.
   logic                rdy_b;
   logic                vld_b_ff;
   hsv_sector_type      sect_b_ff;
   logic [MUL_W-1:0]    mul_q_b_ff;
   logic [MUL_W-1:0]    mul_t_b_ff;
   logic [P_MUL_W-1:0]  mul_p_b_ff;

   // Stage C: scaled-down levels.
   logic                rdy_c;
   logic                vld_c_ff;
   hsv_level_type       level_c_ff;
   hsv_level_type       level_c_in;
   logic [RECIP_PROD_W-1:0] recip_q;
   logic [RECIP_PROD_W-1:0] recip_t;
   logic [P_MUL_W:0]        p_sum;

   assign rdy_c = !vld_c_ff || out_ready;
   assign rdy_b = !vld_b_ff || rdy_c;
   assign rdy_a = !vld_a_ff || rdy_b;

   assign in_ready  = rdy_a;
   assign out_valid = vld_c_ff;
   assign out_level = level_c_ff;

   always_comb begin
      rest_frac  = (FRAC_W+1)'(SECTOR_DEG) - (FRAC_W+1)'(in_angle.frac);
      num_q_a_in = NUM_W'(FRAC_SCALE) - NUM_W'(in_angle.frac) * NUM_W'(saturation);
      num_t_a_in = NUM_W'(FRAC_SCALE) - NUM_W'(rest_frac) * NUM_W'(saturation);
      num_p_a_in = CHAN_W'(FULL_SCALE) - saturation;
   end

   always_comb begin
      recip_q = RECIP_PROD_W'(mul_q_b_ff) * RECIP_PROD_W'(FRAC_RECIP);
      recip_t = RECIP_PROD_W'(mul_t_b_ff) * RECIP_PROD_W'(FRAC_RECIP);
      // Division by 255 of a value no larger than 255 * 255.
      p_sum   = (P_MUL_W+1)'(mul_p_b_ff) + (P_MUL_W+1)'(mul_p_b_ff[P_MUL_W-1:CHAN_W])
                + (P_MUL_W+1)'(1);
      level_c_in.sector  = sect_b_ff;
      level_c_in.level_q = recip_q[FRAC_RECIP_SHIFT +: CHAN_W];
      level_c_in.level_t = recip_t[FRAC_RECIP_SHIFT +: CHAN_W];
      level_c_in.level_p = p_sum[CHAN_W +: CHAN_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            vld_a_ff <= in_valid;
         end
         if (rdy_b) begin
            vld_b_ff <= vld_a_ff;
         end
         if (rdy_c) begin
            vld_c_ff <= vld_b_ff;
         end
      end
      if (rdy_a && in_valid) begin
         sect_a_ff  <= in_angle.sector;
         num_q_a_ff <= num_q_a_in;
         num_t_a_ff <= num_t_a_in;
         num_p_a_ff <= num_p_a_in;
      end
      if (rdy_b && vld_a_ff) begin
         sect_b_ff  <= sect_a_ff;
         mul_q_b_ff <= MUL_W'(brightness) * MUL_W'(num_q_a_ff);
         mul_t_b_ff <= MUL_W'(brightness) * MUL_W'(num_t_a_ff);
         mul_p_b_ff <= P_MUL_W'(brightness) * P_MUL_W'(num_p_a_ff);
      end
      if (rdy_c && vld_b_ff) begin
         level_c_ff <= level_c_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hsv_to_rgb_converter.sv -----
// Top level of the HSV to RGB converter: configuration registers, pipeline and output routing.
//
// Each req_ beat carries a hue in whole degrees; each rsp_ beat carries the red,
// green and blue levels for one hue, in the order the hues arrived. Saturation
// (register 0) and brightness (register 1) are written through the csr_ port and
// apply to every later hue; writes to other indexes are ignored.
// The block is a five-stage pipeline: hue split, numerators, brightness products,
// reciprocal scaling and the output register that routes levels by sector. A
// result becomes valid once its hue has passed through every stage in that order,
// and one hue is accepted every cycle while the output is taken.
// The output register parts the channels: while rsp_stall is high the result is
// held, and empty stages behind it still fill, so req_stall rises only when every
// stage holds a beat. Nothing is lost or repeated under a stall.
// Reset empties the pipeline and sets both saturation and brightness to 255.
`default_nettype none

module hsv_to_rgb_converter
   import hsv_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [HUE_W-1:0]       req_hue_degrees,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [CHAN_W-1:0]           rsp_red,
   output logic [CHAN_W-1:0]           rsp_green,
   output logic [CHAN_W-1:0]           rsp_blue,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [CHAN_W-1:0] saturation_ff;
   logic [CHAN_W-1:0] brightness_ff;

   logic              sector_ready;
   logic              angle_valid;
   hsv_angle_type     angle;
   logic              angle_ready;
   logic              level_valid;
   hsv_level_type     level;
   logic              out_ready;

   logic              out_vld_ff;
   logic [CHAN_W-1:0] red_ff;
   logic [CHAN_W-1:0] green_ff;
   logic [CHAN_W-1:0] blue_ff;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         saturation_ff <= CHAN_W'(FULL_SCALE);
         brightness_ff <= CHAN_W'(FULL_SCALE);
      end else if (csr_write_enable) begin
         if (csr_index == CSR_SATURATION) begin
            saturation_ff <= csr_write_data[CHAN_W-1:0];
         end
         if (csr_index == CSR_BRIGHTNESS) begin
            brightness_ff <= csr_write_data[CHAN_W-1:0];
         end
      end
   end

   hsv_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_hue    (req_hue_degrees),
      .in_ready  (sector_ready),
      .out_valid (angle_valid),
      .out_angle (angle),
      .out_ready (angle_ready)
   );

   hsv_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .saturation (saturation_ff),
      .brightness (brightness_ff),
      .in_valid   (angle_valid),
      .in_angle   (angle),
      .in_ready   (angle_ready),
      .out_valid  (level_valid),
      .out_level  (level),
      .out_ready  (out_ready)
   );

   assign req_stall = !sector_ready;
   assign out_ready = !out_vld_ff || !rsp_stall;

   always_comb begin
      case (level.sector)
         SECT_RED_YELLOW: begin
            red_in = brightness_ff; green_in = level.level_t; blue_in = level.level_p;
         end
         SECT_YELLOW_GREEN: begin
            red_in = level.level_q; green_in = brightness_ff; blue_in = level.level_p;
         end
         SECT_GREEN_CYAN: begin
            red_in = level.level_p; green_in = brightness_ff; blue_in = level.level_t;
         end
         SECT_CYAN_BLUE: begin
            red_in = level.level_p; green_in = level.level_q; blue_in = brightness_ff;
         end
         SECT_BLUE_MAGENTA: begin
            red_in = level.level_t; green_in = level.level_p; blue_in = brightness_ff;
         end
         default: begin
            red_in = brightness_ff; green_in = level.level_p; blue_in = level.level_q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_ready) begin
         out_vld_ff <= level_valid;
      end
      if (out_ready && level_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

`default_nettype wire
